/* hw/rtl/btst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btst_pkg
// Shared constants, types and helpers for the backend transaction tracker.
// ----------------------------------------------------------------------------
package btst_pkg;

    localparam int COUNTER_BITS = 32;

    // Output widths
    localparam int TX_COUNT_BITS = 32;
    localparam int M_TDATA_BITS  = 48;

    // Parser phase codes
    localparam logic [2:0] PH_KIND = 3'd0;
    localparam logic [2:0] PH_LEN0 = 3'd1;
    localparam logic [2:0] PH_LEN1 = 3'd2;
    localparam logic [2:0] PH_LEN2 = 3'd3;
    localparam logic [2:0] PH_LEN3 = 3'd4;
    localparam logic [2:0] PH_BODY = 3'd5;

    // Message kinds and status characters
    localparam logic [7:0] KIND_READY = 8'h5A;   // 'Z'
    localparam logic [7:0] KIND_ERROR = 8'h45;   // 'E'
    localparam logic [7:0] STATUS_IDLE = 8'h49;  // 'I'

    // Payload positions of interest
    localparam logic [2:0] IDX_STATUS  = 3'd0;
    localparam logic [2:0] IDX_SEV_FIRST = 3'd1;
    localparam logic [2:0] IDX_SEV_LAST  = 3'd5;
    localparam logic [2:0] IDX_MAX       = 3'd7;

    localparam logic [31:0] HDR_LEN = 32'd4;

    // Per-transfer result, kept together between core and top
    typedef struct packed {
        logic [TX_COUNT_BITS-1:0] tx_count;
        logic                     malformed;
        logic                     fatal_seen;
        logic                     tx_done;
        logic                     tx_begin;
        logic                     in_transaction;
        logic                     message_end;
        logic                     message_start;
        logic [7:0]               msg_kind;
    } btst_result_t;

    // Severity text, payload byte 1..5
    function automatic logic [7:0] sev_fatal_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd1:    c = 8'h46;  // F
            3'd2:    c = 8'h41;  // A
            3'd3:    c = 8'h54;  // T
            3'd4:    c = 8'h41;  // A
            3'd5:    c = 8'h4C;  // L
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] sev_panic_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd1:    c = 8'h50;  // P
            3'd2:    c = 8'h41;  // A
            3'd3:    c = 8'h4E;  // N
            3'd4:    c = 8'h49;  // I
            3'd5:    c = 8'h43;  // C
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* hw/rtl/btst_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btst_core
// Message framer and transaction state; one stream byte per enabled cycle.
// ----------------------------------------------------------------------------
module btst_core
    import btst_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,           // consume one byte this cycle
    input  logic [7:0]   data_byte,
    input  logic         session_start,
    output btst_result_t result          // valid while step is high
);

    logic [2:0]              phase_reg,    phase_next;
    logic [7:0]              kind_reg,     kind_next;
    logic [31:0]             lshift_reg,   lshift_next;
    logic [31:0]             left_reg,     left_next;
    logic [2:0]              idx_reg,      idx_next;
    logic                    fmatch_reg,   fmatch_next;
    logic                    pmatch_reg,   pmatch_next;
    logic                    in_tx_reg,    in_tx_next;
    logic                    fatal_reg,    fatal_next;
    logic [COUNTER_BITS-1:0] count_reg,    count_next;

    logic [COUNTER_BITS+TX_COUNT_BITS-1:0] count_ext;

    always_comb
    begin
        logic [2:0]  ph;
        logic [7:0]  kind;
        logic [31:0] lsh;
        logic [31:0] left;
        logic [2:0]  idx;
        logic        fm;
        logic        pm;
        logic        ff;
        logic        now_tx;
        logic        fm_n;
        logic        pm_n;

        // session start: fresh parser, fatal flag cleared
        ph   = session_start ? PH_KIND : phase_reg;
        kind = session_start ? 8'h00   : kind_reg;
        lsh  = session_start ? 32'd0   : lshift_reg;
        left = session_start ? 32'd0   : left_reg;
        idx  = session_start ? 3'd0    : idx_reg;
        fm   = session_start ? 1'b1    : fmatch_reg;
        pm   = session_start ? 1'b1    : pmatch_reg;
        ff   = session_start ? 1'b0    : fatal_reg;

        phase_next  = ph;
        kind_next   = kind;
        lshift_next = lsh;
        left_next   = left;
        idx_next    = idx;
        fmatch_next = fm;
        pmatch_next = pm;
        in_tx_next  = in_tx_reg;
        fatal_next  = ff;
        count_next  = count_reg;

        result               = '0;
        now_tx               = 1'b0;
        fm_n                 = fm;
        pm_n                 = pm;

        if (ph == PH_LEN0 || ph == PH_LEN1 || ph == PH_LEN2 || ph == PH_LEN3)
        begin
            lshift_next = {lsh[23:0], data_byte};
            if (ph != PH_LEN3)
            begin
                phase_next = ph + 3'd1;
            end
            else if (lshift_next <= HDR_LEN)
            begin
                // short or empty: message ends on last length byte
                result.malformed   = (lshift_next < HDR_LEN);
                result.message_end = 1'b1;
                phase_next         = PH_KIND;
            end
            else
            begin
                left_next  = lshift_next - HDR_LEN;
                idx_next   = 3'd0;
                phase_next = PH_BODY;
            end
        end
        else if (ph == PH_BODY)
        begin
            if (kind == KIND_READY && idx == IDX_STATUS)
            begin
                now_tx = (data_byte != STATUS_IDLE);
                if (now_tx && !in_tx_reg)
                begin
                    result.tx_begin = 1'b1;
                    count_next      = count_reg + COUNTER_BITS'(1);
                end
                in_tx_next = now_tx;
            end
            if (kind == KIND_ERROR && idx >= IDX_SEV_FIRST && idx <= IDX_SEV_LAST)
            begin
                if (data_byte != sev_fatal_char(idx))
                begin
                    fm_n = 1'b0;
                end
                if (data_byte != sev_panic_char(idx))
                begin
                    pm_n = 1'b0;
                end
                fmatch_next = fm_n;
                pmatch_next = pm_n;
                if (idx == IDX_SEV_LAST && (fm_n || pm_n))
                begin
                    fatal_next = 1'b1;
                end
            end
            if (idx != IDX_MAX)
            begin
                idx_next = idx + 3'd1;
            end
            left_next = left - 32'd1;
            if (left == 32'd1)
            begin
                result.message_end = 1'b1;
                phase_next         = PH_KIND;
                if (kind == KIND_READY && !in_tx_next)
                begin
                    result.tx_done = 1'b1;
                end
            end
        end
        else
        begin
            kind_next            = data_byte;
            result.message_start = 1'b1;
            lshift_next          = 32'd0;
            left_next            = 32'd0;
            idx_next             = 3'd0;
            fmatch_next          = 1'b1;
            pmatch_next          = 1'b1;
            phase_next           = PH_LEN0;
        end

        result.msg_kind       = kind_next;
        result.in_transaction = in_tx_next;
        result.fatal_seen     = fatal_next;

        // counter view: low bits, zero-filled when narrower than the port
        count_ext       = {{TX_COUNT_BITS{1'b0}}, count_next};
        result.tx_count = count_ext[TX_COUNT_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_KIND;
            kind_reg   <= '0;
            lshift_reg <= '0;
            left_reg   <= '0;
            idx_reg    <= '0;
            fmatch_reg <= 1'b1;
            pmatch_reg <= 1'b1;
            in_tx_reg  <= 1'b0;
            fatal_reg  <= 1'b0;
            count_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            lshift_reg <= lshift_next;
            left_reg   <= left_next;
            idx_reg    <= idx_next;
            fmatch_reg <= fmatch_next;
            pmatch_reg <= pmatch_next;
            in_tx_reg  <= in_tx_next;
            fatal_reg  <= fatal_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hw/rtl/backend_transaction_state_tracker_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// backend_transaction_state_tracker_unit
// Frames a server-to-client database wire stream byte by byte and tracks
// transaction state, transaction count and fatal error responses.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Signals                     Content
//  --------  ---  --------------------------  -------------------------------
//  s_axis    in   tvalid tready tdata tuser   tdata: data_byte
//                                             tuser: session_start
//  m_axis    out  tvalid tready tdata tuser   tdata: per-byte status (below)
//                 tlast                       tuser: message_start
//                                             tlast: message_end
//
//  One result transfer per input byte, in order.
//  Path: input register, then result register, with the parser step between
//  them; the result register loads only when it is free or being taken.
//  Throughput: one byte per cycle while m_axis is not stalled, set by the
//  single parser step between the two registers.
//  Reset (rst_n low, asynchronous) empties both registers, returns the parser
//  to the kind byte, clears transaction state, fatal flag and count.
//  A stall on m_axis holds the result; s_axis keeps accepting until the input
//  register is also full, then s_tready drops until the result is taken.
//
module backend_transaction_state_tracker_unit
    import btst_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,   // [7:0] data_byte
    input  logic                    s_tuser,   // [0] session_start

    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_BITS-1:0] m_tdata,   // [7:0] msg_kind, [8] in_transaction,
                                               // [9] tx_begin, [10] tx_done,
                                               // [11] fatal_seen, [12] malformed,
                                               // [44:13] tx_count, [47:45] zero
    output logic                    m_tuser,   // [0] message_start
    output logic                    m_tlast    // message_end
);

    // input register
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_start_reg;

    // result register
    logic         out_valid_reg;
    btst_result_t out_reg;

    btst_result_t step_result;
    logic         advance;

    // move input byte into the result register when that slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    btst_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .data_byte     (in_byte_reg),
        .session_start (in_start_reg),
        .result        (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
        if (advance)
        begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.message_start;
    assign m_tlast  = out_reg.message_end;
    assign m_tdata  = {3'b000,
                       out_reg.tx_count,
                       out_reg.malformed,
                       out_reg.fatal_seen,
                       out_reg.tx_done,
                       out_reg.tx_begin,
                       out_reg.in_transaction,
                       out_reg.msg_kind};

endmodule
